// File: hw/rtl/slot_pool_lease_manager_core_defines.svh
// Assertion helpers used by the lease manager core.
// Every macro expects signals named clock and reset in the using scope.
`ifndef SLOT_POOL_LEASE_MANAGER_CORE_DEFINES_SVH
`define SLOT_POOL_LEASE_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define SPLM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPLM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/splm_pkg.sv
`timescale 1ns / 1ps

package splm_pkg;

   // beat field widths
   localparam int KIND_W     = 3;
   localparam int SLOT_W     = 5;
   localparam int NOW_W      = 64;
   localparam int STATUS_W   = 2;
   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 6;

   // register widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ACTIVE_W   = 6;
   localparam int SBYTES_W   = 17;
   localparam int BASE_W     = 31;
   localparam int TMO_W      = 32;

   // register reset values
   localparam int                  ACTIVE_RST = 32;
   localparam logic [SBYTES_W-1:0] SBYTES_RST = 17'd16;
   localparam logic [BASE_W-1:0]   BASE_RST   = 31'd0;
   localparam logic [TMO_W-1:0]    TMO_RST    = 32'd120000000;

   // request kinds; codes 6 and 7 are no-ops
   typedef enum logic [KIND_W-1:0] {
      KIND_ACQ_WR  = 3'd0,
      KIND_COMMIT  = 3'd1,
      KIND_DISCARD = 3'd2,
      KIND_ACQ_RD  = 3'd3,
      KIND_RELEASE = 3'd4,
      KIND_SCAN    = 3'd5
   } kind_type;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WR_TMO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RD_TMO    = 3'd4;

endpackage

// File: hw/rtl/slot_pool_lease_manager_core.sv
// Queue requests: the result strobe is registered from the EXEC state; busy holds off a new request until idle.
// Stale scan: walks the n active slots (n = active slot count), result strobe registered from the DRAIN state;
//   one slot is checked per cycle by the shared age comparator, write pass then read pass.
// The receiver cannot stall; each result is shown for one cycle on rsp_valid.
// Synchronous active-high reset: all slots free in order, ready queue empty, no leases.
// Writing active_slots rebuilds both queues by resetting their pointers and counts; no memory clearing pass.
`timescale 1ns / 1ps

module slot_pool_lease_manager_core #(
   parameter int SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [splm_pkg::KIND_W-1:0]       req_kind,
   input  logic [splm_pkg::SLOT_W-1:0]       req_slot,
   input  logic [splm_pkg::NOW_W-1:0]        req_now,
   // result channel
   output logic                              rsp_valid,
   output logic [splm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [splm_pkg::SLOT_W-1:0]       rsp_granted_slot,
   output logic [splm_pkg::ADDR_W-1:0]       rsp_slot_address,
   output logic [splm_pkg::COUNT_W-1:0]      rsp_free_count,
   output logic [splm_pkg::COUNT_W-1:0]      rsp_ready_count,
   output logic [splm_pkg::COUNT_W-1:0]      rsp_reclaimed,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [splm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [splm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import splm_pkg::*;

`include "slot_pool_lease_manager_core_defines.svh"

   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = SW + 1;
   localparam int NW    = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int SZ_W  = SBYTES_W + 1;
   localparam int PR_W  = SW + SZ_W;
   localparam int N_RST = (ACTIVE_RST < SLOTS) ? ACTIVE_RST : SLOTS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN
   } st_type;

   // sequencer and request latch
   st_type              state_ff, state_in;
   kind_type            kind_ff, kind_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [NOW_W-1:0]    now_ff, now_in;

   // configuration
   logic [CW-1:0]       n_ff, n_in;
   logic [SBYTES_W-1:0] sbytes_ff, sbytes_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [TMO_W-1:0]    wr_tmo_ff, wr_tmo_in;
   logic [TMO_W-1:0]    rd_tmo_ff, rd_tmo_in;

   // queue pointers
   logic [SW-1:0]       free_head_ff, free_head_in;
   logic [SW-1:0]       free_tail_ff, free_tail_in;
   logic [CW-1:0]       free_total_ff, free_total_in;
   logic [CW-1:0]       free_fill_ff, free_fill_in;
   logic [SW-1:0]       ready_head_ff, ready_head_in;
   logic [SW-1:0]       ready_tail_ff, ready_tail_in;
   logic [CW-1:0]       ready_total_ff, ready_total_in;

   // lease flags
   logic [SLOTS-1:0]    wbusy_ff, wbusy_in;
   logic [SLOTS-1:0]    rbusy_ff, rbusy_in;

   // scan walker and evaluation stage
   logic [SW-1:0]       scan_idx_ff, scan_idx_in;
   logic                scan_pass_ff, scan_pass_in;
   logic                eval_vld_ff, eval_vld_in;
   logic [SW-1:0]       eval_idx_ff, eval_idx_in;
   logic                eval_pass_ff, eval_pass_in;
   logic [CW-1:0]       reclaim_ff, reclaim_in;

   // result registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]       rsp_grant_ff, rsp_grant_in;
   logic [ADDR_W-1:0]   rsp_prod_ff, rsp_prod_in;
   logic [BASE_W-1:0]   rsp_base_ff, rsp_base_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;
   logic [COUNT_W-1:0]  rsp_ready_ff, rsp_ready_in;
   logic [COUNT_W-1:0]  rsp_reclaim_ff, rsp_reclaim_in;

   // memory ports
   logic                fq_we;
   logic [SW-1:0]       fq_rdata;
   logic                rq_we;
   logic [SW-1:0]       rq_rdata;
   logic                ws_we;
   logic [NOW_W-1:0]    ws_rdata;
   logic                rs_we;
   logic [NOW_W-1:0]    rs_rdata;

   // push requests from the request decode or the scan stage
   logic                fpush;
   logic [SW-1:0]       fpush_val;
   logic                rpush;
   logic [SW-1:0]       rpush_val;

   // shared datapath
   logic                req_accept;
   logic                csr_write;
   logic [NW-1:0]       slot_w;
   logic [SW-1:0]       slot_idx;
   logic                slot_ok;
   logic                free_written;
   logic [SW-1:0]       free_pop_slot;
   logic [SW-1:0]       acq_slot;
   logic [SZ_W-1:0]     sz_sum;
   logic [SZ_W-1:0]     slot_sz;
   logic [PR_W-1:0]     prod_full;
   logic [NOW_W-1:0]    eval_stamp;
   logic [TMO_W-1:0]    eval_limit;
   logic                eval_busy;
   logic                eval_stale;
   logic                scan_last;
   logic [CW-1:0]       act_eff;

   // next pointer position, wrapping at the active count
   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p, input logic [CW-1:0] n);
      logic [CW-1:0] p1;
      p1 = {1'b0, p} + CW'(1);
      return (p1 == n) ? '0 : p1[SW-1:0];
   endfunction

   assign req_accept = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;

   // request slot range check
   assign slot_w   = NW'(slot_ff);
   assign slot_idx = slot_w[SW-1:0];
   assign slot_ok  = slot_w < NW'(n_ff);

   // free queue entries not yet written since rebuild hold their own index
   assign free_written  = {1'b0, free_head_ff} < free_fill_ff;
   assign free_pop_slot = free_written ? fq_rdata : free_head_ff;
   assign acq_slot      = (kind_ff == KIND_ACQ_RD) ? rq_rdata : free_pop_slot;

   // slot size rounded up to 16 bytes, then offset of the granted slot
   assign sz_sum    = {1'b0, sbytes_ff} + SZ_W'(15);
   assign slot_sz   = {sz_sum[SZ_W-1:4], 4'b0000};
   assign prod_full = slot_sz * acq_slot;

   // scan evaluation operands
   assign eval_stamp = eval_pass_ff ? rs_rdata : ws_rdata;
   assign eval_limit = eval_pass_ff ? rd_tmo_ff : wr_tmo_ff;
   assign eval_busy  = eval_pass_ff ? rbusy_ff[eval_idx_ff] : wbusy_ff[eval_idx_ff];
   assign scan_last  = ({1'b0, scan_idx_ff} + CW'(1)) == n_ff;

   // effective active count of a register write
   always_comb begin
      if (csr_wdata[ACTIVE_W-1:0] == '0) begin
         act_eff = CW'(1);
      end else if (32'(csr_wdata[ACTIVE_W-1:0]) > SLOTS) begin
         act_eff = CW'(SLOTS);
      end else begin
         act_eff = CW'(csr_wdata[ACTIVE_W-1:0]);
      end
   end

   splm_age_cmp u_age_cmp (
      .now   (now_ff),
      .stamp (eval_stamp),
      .limit (eval_limit),
      .stale (eval_stale)
   );

   splm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_q (
      .clock (clock),
      .we    (fq_we),
      .waddr (free_tail_ff),
      .wdata (fpush_val),
      .raddr (free_head_ff),
      .rdata (fq_rdata)
   );

   splm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ready_q (
      .clock (clock),
      .we    (rq_we),
      .waddr (ready_tail_ff),
      .wdata (rpush_val),
      .raddr (ready_head_ff),
      .rdata (rq_rdata)
   );

   splm_ram #(.WIDTH(NOW_W), .DEPTH(SLOTS)) u_wr_stamp (
      .clock (clock),
      .we    (ws_we),
      .waddr (acq_slot),
      .wdata (now_ff),
      .raddr (scan_idx_ff),
      .rdata (ws_rdata)
   );

   splm_ram #(.WIDTH(NOW_W), .DEPTH(SLOTS)) u_rd_stamp (
      .clock (clock),
      .we    (rs_we),
      .waddr (acq_slot),
      .wdata (now_ff),
      .raddr (scan_idx_ff),
      .rdata (rs_rdata)
   );

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      slot_in        = slot_ff;
      now_in         = now_ff;
      n_in           = n_ff;
      sbytes_in      = sbytes_ff;
      base_in        = base_ff;
      wr_tmo_in      = wr_tmo_ff;
      rd_tmo_in      = rd_tmo_ff;
      free_head_in   = free_head_ff;
      free_tail_in   = free_tail_ff;
      free_total_in  = free_total_ff;
      free_fill_in   = free_fill_ff;
      ready_head_in  = ready_head_ff;
      ready_tail_in  = ready_tail_ff;
      ready_total_in = ready_total_ff;
      wbusy_in       = wbusy_ff;
      rbusy_in       = rbusy_ff;
      scan_idx_in    = scan_idx_ff;
      scan_pass_in   = scan_pass_ff;
      eval_vld_in    = 1'b0;
      eval_idx_in    = eval_idx_ff;
      eval_pass_in   = eval_pass_ff;
      reclaim_in     = reclaim_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_grant_in   = rsp_grant_ff;
      rsp_prod_in    = rsp_prod_ff;
      rsp_base_in    = rsp_base_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_ready_in   = rsp_ready_ff;
      rsp_reclaim_in = rsp_reclaim_ff;
      ws_we          = 1'b0;
      rs_we          = 1'b0;
      fpush          = 1'b0;
      fpush_val      = '0;
      rpush          = 1'b0;
      rpush_val      = '0;
      fq_we          = 1'b0;
      rq_we          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in  = kind_type'(req_kind);
               slot_in  = req_slot;
               now_in   = req_now;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_DONE;
            rsp_grant_in   = '0;
            rsp_prod_in    = '0;
            rsp_base_in    = '0;
            rsp_reclaim_in = '0;
            unique case (kind_ff)
               KIND_ACQ_WR: begin
                  if (free_total_ff == '0) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     free_head_in       = wrap_inc(free_head_ff, n_ff);
                     free_total_in      = free_total_ff - CW'(1);
                     wbusy_in[acq_slot] = 1'b1;
                     ws_we              = 1'b1;
                     rsp_grant_in       = acq_slot;
                     rsp_prod_in        = ADDR_W'(prod_full);
                     rsp_base_in        = base_ff;
                  end
               end
               KIND_COMMIT: begin
                  if (!slot_ok || !wbusy_ff[slot_idx]) begin
                     rsp_status_in = STATUS_IGNORED;
                  end else begin
                     wbusy_in[slot_idx] = 1'b0;
                     rpush              = 1'b1;
                     rpush_val          = slot_idx;
                  end
               end
               KIND_DISCARD: begin
                  if (!slot_ok || !wbusy_ff[slot_idx]) begin
                     rsp_status_in = STATUS_IGNORED;
                  end else begin
                     wbusy_in[slot_idx] = 1'b0;
                     fpush              = 1'b1;
                     fpush_val          = slot_idx;
                  end
               end
               KIND_ACQ_RD: begin
                  if (ready_total_ff == '0) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     ready_head_in      = wrap_inc(ready_head_ff, n_ff);
                     ready_total_in     = ready_total_ff - CW'(1);
                     rbusy_in[acq_slot] = 1'b1;
                     rs_we              = 1'b1;
                     rsp_grant_in       = acq_slot;
                     rsp_prod_in        = ADDR_W'(prod_full);
                     rsp_base_in        = base_ff;
                  end
               end
               KIND_RELEASE: begin
                  if (!slot_ok || !rbusy_ff[slot_idx]) begin
                     rsp_status_in = STATUS_IGNORED;
                  end else begin
                     rbusy_in[slot_idx] = 1'b0;
                     fpush              = 1'b1;
                     fpush_val          = slot_idx;
                  end
               end
               KIND_SCAN: begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_SCAN;
                  scan_idx_in  = '0;
                  scan_pass_in = 1'b0;
                  reclaim_in   = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            // issue stamp read for this slot, evaluated next cycle
            eval_vld_in  = 1'b1;
            eval_idx_in  = scan_idx_ff;
            eval_pass_in = scan_pass_ff;
            if (scan_last) begin
               scan_idx_in = '0;
               if (scan_pass_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  scan_pass_in = 1'b1;
               end
            end else begin
               scan_idx_in = scan_idx_ff + SW'(1);
            end
         end
         ST_DRAIN: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_DONE;
            rsp_grant_in   = '0;
            rsp_prod_in    = '0;
            rsp_base_in    = '0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // scan evaluation: reclaim a stale lease
      if (eval_vld_ff && eval_busy && eval_stale) begin
         wbusy_in[eval_idx_ff] = 1'b0;
         rbusy_in[eval_idx_ff] = 1'b0;
         fpush                 = 1'b1;
         fpush_val             = eval_idx_ff;
         reclaim_in            = reclaim_ff + CW'(1);
      end

      // free queue push, dropped when full
      if (fpush && (free_total_ff < n_ff)) begin
         fq_we         = 1'b1;
         free_tail_in  = wrap_inc(free_tail_ff, n_ff);
         free_total_in = free_total_ff + CW'(1);
         if (free_fill_ff < n_ff) begin
            free_fill_in = free_fill_ff + CW'(1);
         end
      end

      // ready queue push, dropped when full
      if (rpush && (ready_total_ff < n_ff)) begin
         rq_we          = 1'b1;
         ready_tail_in  = wrap_inc(ready_tail_ff, n_ff);
         ready_total_in = ready_total_ff + CW'(1);
      end

      // counts reported after this step
      if (state_ff == ST_DRAIN) begin
         rsp_reclaim_in = COUNT_W'(reclaim_in);
      end
      if (rsp_valid_in) begin
         rsp_free_in  = COUNT_W'(free_total_in);
         rsp_ready_in = COUNT_W'(ready_total_in);
      end

      // register writes; active count rebuilds both queues
      if (csr_write) begin
         unique case (csr_index)
            REG_ACTIVE: begin
               n_in           = act_eff;
               free_head_in   = '0;
               free_tail_in   = '0;
               free_total_in  = act_eff;
               free_fill_in   = '0;
               ready_head_in  = '0;
               ready_tail_in  = '0;
               ready_total_in = '0;
               wbusy_in       = '0;
               rbusy_in       = '0;
            end
            REG_SLOT_SIZE: sbytes_in = csr_wdata[SBYTES_W-1:0];
            REG_DATA_BASE: base_in   = csr_wdata[BASE_W-1:0];
            REG_WR_TMO:    wr_tmo_in = csr_wdata[TMO_W-1:0];
            REG_RD_TMO:    rd_tmo_in = csr_wdata[TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      slot_ff        <= slot_in;
      now_ff         <= now_in;
      eval_idx_ff    <= eval_idx_in;
      eval_pass_ff   <= eval_pass_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_grant_ff   <= rsp_grant_in;
      rsp_prod_ff    <= rsp_prod_in;
      rsp_base_ff    <= rsp_base_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_ready_ff   <= rsp_ready_in;
      rsp_reclaim_ff <= rsp_reclaim_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         n_ff           <= CW'(N_RST);
         sbytes_ff      <= SBYTES_RST;
         base_ff        <= BASE_RST;
         wr_tmo_ff      <= TMO_RST;
         rd_tmo_ff      <= TMO_RST;
         free_head_ff   <= '0;
         free_tail_ff   <= '0;
         free_total_ff  <= CW'(N_RST);
         free_fill_ff   <= '0;
         ready_head_ff  <= '0;
         ready_tail_ff  <= '0;
         ready_total_ff <= '0;
         wbusy_ff       <= '0;
         rbusy_ff       <= '0;
         scan_idx_ff    <= '0;
         scan_pass_ff   <= 1'b0;
         eval_vld_ff    <= 1'b0;
         reclaim_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         n_ff           <= n_in;
         sbytes_ff      <= sbytes_in;
         base_ff        <= base_in;
         wr_tmo_ff      <= wr_tmo_in;
         rd_tmo_ff      <= rd_tmo_in;
         free_head_ff   <= free_head_in;
         free_tail_ff   <= free_tail_in;
         free_total_ff  <= free_total_in;
         free_fill_ff   <= free_fill_in;
         ready_head_ff  <= ready_head_in;
         ready_tail_ff  <= ready_tail_in;
         ready_total_ff <= ready_total_in;
         wbusy_ff       <= wbusy_in;
         rbusy_ff       <= rbusy_in;
         scan_idx_ff    <= scan_idx_in;
         scan_pass_ff   <= scan_pass_in;
         eval_vld_ff    <= eval_vld_in;
         reclaim_ff     <= reclaim_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result beat
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = SLOT_W'(rsp_grant_ff);
   assign rsp_slot_address = {1'b0, rsp_base_ff} + rsp_prod_ff;
   assign rsp_free_count   = rsp_free_ff;
   assign rsp_ready_count  = rsp_ready_ff;
   assign rsp_reclaimed    = rsp_reclaim_ff;

   // checks
   `SPLM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `SPLM_ASSERT_IMP(a_strobe_idle, rsp_valid_ff, state_ff == ST_IDLE, "result beat while working")
   `SPLM_ASSERT_IMP(a_count_bound, 1'b1, (free_total_ff <= n_ff) && (ready_total_ff <= n_ff) && (free_fill_ff <= n_ff), "queue count beyond active slots")
   `SPLM_ASSERT_IMP(a_grant_lease, rsp_valid_ff && (kind_ff == KIND_ACQ_WR) && (rsp_status_ff == STATUS_DONE), wbusy_ff[rsp_grant_ff], "granted write slot not leased")
   `SPLM_ASSERT_IMP(a_eval_in_scan, eval_vld_ff, (state_ff == ST_SCAN) || (state_ff == ST_DRAIN), "scan evaluation outside scan")

endmodule

// File: hw/rtl/splm_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module splm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read, read returns old data on collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/splm_age_cmp.sv
`timescale 1ns / 1ps

// Lease age check: stale when (now - stamp) mod 2^64 exceeds the limit.
module splm_age_cmp (
   input  logic [splm_pkg::NOW_W-1:0] now,
   input  logic [splm_pkg::NOW_W-1:0] stamp,
   input  logic [splm_pkg::TMO_W-1:0] limit,
   output logic                       stale
);

   import splm_pkg::*;

   logic [NOW_W-1:0] age;

   assign age   = now - stamp;
   assign stale = age > {{(NOW_W-TMO_W){1'b0}}, limit};

endmodule
